>>> design/i2cma_pkg.sv
// ----------------------------------------------------------------------------
// i2cma_pkg: shared types and constants for the I2C register access master
// Step counts, request codes, register indexes and the pin action record.
// ----------------------------------------------------------------------------
package i2cma_pkg;

   localparam int DIVIDER_WIDTH = 16;
   localparam int TICKS_WIDTH   = 16;
   // compare width: wide enough for the divider count plus one and the hold
   localparam int CMP_WIDTH = (DIVIDER_WIDTH + 1 > TICKS_WIDTH) ?
                              DIVIDER_WIDTH + 1 : TICKS_WIDTH;

   localparam logic [6:0] WRITE_STEPS = 7'd91;
   localparam logic [6:0] READ_STEPS  = 7'd123;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic CSR_DEVICE_ADDRESS = 1'b0;
   localparam logic CSR_STEP_TICKS     = 1'b1;

   typedef enum logic [1:0] {
      ACT_SDA  = 2'd0,   // drive SDA to value
      ACT_SCL  = 2'd1,   // drive SCL to value
      ACT_ACK  = 2'd2,   // sample ACK into slot
      ACT_RECV = 2'd3    // shift sampled bit into receive byte
   } act_type;

   typedef struct packed {
      act_type    act;
      logic       value;
      logic [1:0] slot;
   } step_action_type;

endpackage

>>> design/i2cma_step_decode.sv
// ----------------------------------------------------------------------------
// i2cma_step_decode: pin action lookup for one step of the sequence
// Maps a 0-based step position to the segment, offset and pin action.
// ----------------------------------------------------------------------------
module i2cma_step_decode
   import i2cma_pkg::*;
(
   input  logic [6:0]      pos,
   input  logic            is_read,
   input  logic [6:0]      device_address,
   input  logic [7:0]      reg_byte,
   input  logic [7:0]      data_byte,
   output step_action_type action
);

   typedef enum logic [2:0] {
      SEG_START = 3'd0,
      SEG_BYTE  = 3'd1,
      SEG_ACK   = 3'd2,
      SEG_RECV  = 3'd3,
      SEG_NACK  = 3'd4,
      SEG_STOP  = 3'd5
   } seg_type;

   seg_type    seg;
   logic [6:0] base;
   logic [1:0] slot;
   logic [7:0] tx_byte;
   logic [4:0] offs;
   logic [4:0] offs_adj;
   logic [8:0] mul;
   logic [2:0] bit_q;
   logic [1:0] bit_r;
   logic [4:0] three_q;

   always_comb begin
      seg     = SEG_STOP;
      base    = 7'd0;
      slot    = 2'd0;
      tx_byte = data_byte;
      priority if (pos < 7'd4) begin
         seg = SEG_START;
      end else if (pos < 7'd28) begin
         seg = SEG_BYTE; base = 7'd4; tx_byte = {device_address, 1'b0};
      end else if (pos < 7'd32) begin
         seg = SEG_ACK; base = 7'd28;
      end else if (pos < 7'd56) begin
         seg = SEG_BYTE; base = 7'd32; tx_byte = reg_byte;
      end else if (pos < 7'd60) begin
         seg = SEG_ACK; base = 7'd56; slot = 2'd1;
      end else if (!is_read) begin
         priority if (pos < 7'd84) begin
            seg = SEG_BYTE; base = 7'd60; tx_byte = data_byte;
         end else if (pos < 7'd88) begin
            seg = SEG_ACK; base = 7'd84; slot = 2'd2;
         end else begin
            seg = SEG_STOP; base = 7'd88;
         end
      end else begin
         priority if (pos < 7'd64) begin
            seg = SEG_START; base = 7'd60;
         end else if (pos < 7'd88) begin
            seg = SEG_BYTE; base = 7'd64; tx_byte = {device_address, 1'b1};
         end else if (pos < 7'd92) begin
            seg = SEG_ACK; base = 7'd88; slot = 2'd2;
         end else if (pos < 7'd117) begin
            seg = SEG_RECV; base = 7'd92;
         end else if (pos < 7'd120) begin
            seg = SEG_NACK; base = 7'd117;
         end else begin
            seg = SEG_STOP; base = 7'd120;
         end
      end
   end

   always_comb begin
      logic [6:0] diff;
      diff     = pos - base;
      offs     = diff[4:0];
      // receive bits start one step into the segment
      offs_adj = (seg == SEG_RECV) ? offs - 5'd1 : offs;
      // divide by 3 through reciprocal, exact over the 24 byte offsets
      mul      = {4'd0, offs_adj} * 9'd11;
      bit_q    = mul[7:5];
      three_q  = {2'd0, bit_q} + {1'b0, bit_q, 1'b0};
      bit_r    = 2'(offs_adj - three_q);
   end

   always_comb begin
      action.act   = ACT_SCL;
      action.value = 1'b0;
      action.slot  = slot;
      unique case (seg)
         SEG_START: begin
            unique case (offs[1:0])
               2'd0: begin action.act = ACT_SDA; action.value = 1'b1; end
               2'd1: begin action.act = ACT_SCL; action.value = 1'b1; end
               2'd2: begin action.act = ACT_SDA; action.value = 1'b0; end
               default: begin action.act = ACT_SCL; action.value = 1'b0; end
            endcase
         end
         SEG_ACK: begin
            unique case (offs[1:0])
               2'd0: begin action.act = ACT_SDA; action.value = 1'b1; end
               2'd1: begin action.act = ACT_SCL; action.value = 1'b1; end
               2'd2: action.act = ACT_ACK;
               default: begin action.act = ACT_SCL; action.value = 1'b0; end
            endcase
         end
         SEG_RECV: begin
            if (offs == 5'd0) begin
               action.act = ACT_SDA; action.value = 1'b1;
            end else begin
               unique case (bit_r)
                  2'd0: begin action.act = ACT_SCL; action.value = 1'b1; end
                  2'd1: action.act = ACT_RECV;
                  default: begin action.act = ACT_SCL; action.value = 1'b0; end
               endcase
            end
         end
         SEG_NACK: begin
            unique case (offs[1:0])
               2'd0: begin action.act = ACT_SDA; action.value = 1'b1; end
               2'd1: begin action.act = ACT_SCL; action.value = 1'b1; end
               default: begin action.act = ACT_SCL; action.value = 1'b0; end
            endcase
         end
         SEG_STOP: begin
            unique case (offs[1:0])
               2'd0: begin action.act = ACT_SDA; action.value = 1'b0; end
               2'd1: begin action.act = ACT_SCL; action.value = 1'b1; end
               default: begin action.act = ACT_SDA; action.value = 1'b1; end
            endcase
         end
         SEG_BYTE: begin
            unique case (bit_r)
               2'd0: begin action.act = ACT_SDA; action.value = tx_byte[3'd7 - bit_q]; end
               2'd1: begin action.act = ACT_SCL; action.value = 1'b1; end
               default: begin action.act = ACT_SCL; action.value = 1'b0; end
            endcase
         end
         default: begin action.act = ACT_SCL; action.value = 1'b0; end
      endcase
   end

endmodule

>>> design/i2c_master_register_access.sv
// ----------------------------------------------------------------------------
// i2c_master_register_access: bit-banged I2C single-register master
// Steps SCL/SDA through a write or read transaction, one request per tick.
// ----------------------------------------------------------------------------
// Usage:
//  - Each req_ request is one tick: operation 0 is a plain tick, 1 starts a
//    register write (reg_address, write_data latched), 2 starts a register
//    read. sda_in is the sampled SDA level for that tick.
//  - Every accepted request yields exactly one rsp_ response holding the pin
//    drives, busy/done flags, receive byte, missing-ACK flags and refusal.
//  - Latency: the response is valid the cycle after the request is taken.
//  - Throughput: one request per cycle while req_stall is low; the state
//    update is a single pass through the step decoder between the state
//    registers and the response register.
//  - A write runs 91 pin steps, a read 123, each held step_ticks ticks (zero acts as one).
//  - A start while busy is ignored and flagged with command_refused.
//  - csr_ writes set device_address (index 0) and step_ticks (index 1).
//  - Reset returns to idle with both pins released; no clearing pass.
//  - When rsp_stall is high with a response pending, req_stall rises and the
//    response is held; a request is still taken while the pending response
//    leaves in the same cycle.
// ----------------------------------------------------------------------------
module i2c_master_register_access
   import i2cma_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_reg_address,
   input  logic [7:0]  req_write_data,
   input  logic        req_sda_in,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_scl_out,
   output logic        rsp_sda_out,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic [7:0]  rsp_read_data,
   output logic [2:0]  rsp_ack_missing,
   output logic        rsp_command_refused,
   // configuration
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [15:0] csr_write_data
);

   // configuration registers
   logic [6:0]  device_address_ff;
   logic [15:0] step_ticks_ff;

   // transaction state
   logic [6:0]               step_index_ff, step_index_in;
   logic                     is_read_ff, is_read_in;
   logic [7:0]               held_reg_ff, held_reg_in;
   logic [7:0]               held_data_ff, held_data_in;
   logic [7:0]               rx_shift_ff, rx_shift_in;
   logic [2:0]               ack_ff, ack_in;
   logic [DIVIDER_WIDTH-1:0] div_ff, div_in;
   logic                     scl_ff, scl_in;
   logic                     sda_ff, sda_in;

   // response register
   logic       rsp_valid_ff;
   logic       rsp_scl_ff, rsp_sda_ff, rsp_busy_ff, rsp_done_ff, rsp_refused_ff;
   logic [7:0] rsp_read_ff;
   logic [2:0] rsp_ack_ff;

   logic done_in, refused_in;
   logic accept, idle, is_start, apply_en;
   logic [6:0] dec_pos;
   logic dec_is_read;
   step_action_type action;
   logic [CMP_WIDTH-1:0] cnt, hold, limit;
   logic [6:0] total;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign idle      = (step_index_ff == 7'd0);
   assign is_start  = (req_operation == OP_WRITE) || (req_operation == OP_READ);

   // position of the step being entered this tick
   assign dec_pos     = idle ? 7'd0 : step_index_ff;
   assign dec_is_read = idle ? (req_operation == OP_READ) : is_read_ff;

   i2cma_step_decode u_decode (
      .pos            (dec_pos),
      .is_read        (dec_is_read),
      .device_address (device_address_ff),
      .reg_byte       (held_reg_ff),
      .data_byte      (held_data_ff),
      .action         (action)
   );

   assign cnt   = CMP_WIDTH'(div_ff) + CMP_WIDTH'(1'b1);
   assign hold  = (step_ticks_ff == 16'd0) ? CMP_WIDTH'(1'b1) : CMP_WIDTH'(step_ticks_ff);
   assign limit = CMP_WIDTH'(1'b1) << DIVIDER_WIDTH;
   assign total = is_read_ff ? READ_STEPS : WRITE_STEPS;

   always_comb begin
      step_index_in = step_index_ff;
      is_read_in    = is_read_ff;
      held_reg_in   = held_reg_ff;
      held_data_in  = held_data_ff;
      rx_shift_in   = rx_shift_ff;
      ack_in        = ack_ff;
      div_in        = div_ff;
      scl_in        = scl_ff;
      sda_in        = sda_ff;
      done_in       = 1'b0;
      refused_in    = 1'b0;
      apply_en      = 1'b0;
      if (accept) begin
         if (idle) begin
            if (is_start) begin
               is_read_in  = (req_operation == OP_READ);
               held_reg_in = req_reg_address;
               if (req_operation == OP_WRITE) begin
                  held_data_in = req_write_data;
               end else begin
                  rx_shift_in = 8'd0;
               end
               ack_in        = 3'd0;
               div_in        = '0;
               step_index_in = 7'd1;
               apply_en      = 1'b1;
            end
         end else begin
            refused_in = is_start;
            if ((cnt >= hold) || (cnt >= limit)) begin
               div_in = '0;
               if (step_index_ff >= total) begin
                  step_index_in = 7'd0;
                  done_in       = 1'b1;
               end else begin
                  apply_en      = 1'b1;
                  step_index_in = step_index_ff + 7'd1;
               end
            end else begin
               div_in = cnt[DIVIDER_WIDTH-1:0];
            end
         end
      end
      // pin action of the step just entered
      if (apply_en) begin
         unique case (action.act)
            ACT_SDA:  sda_in = action.value;
            ACT_SCL:  scl_in = action.value;
            ACT_ACK: begin
               if (req_sda_in) ack_in = ack_in | (3'b001 << action.slot);
            end
            ACT_RECV: rx_shift_in = {rx_shift_in[6:0], req_sda_in};
            default:  sda_in = sda_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         device_address_ff <= 7'd97;
         step_ticks_ff     <= 16'd1;
         step_index_ff     <= 7'd0;
         is_read_ff        <= 1'b0;
         held_reg_ff       <= 8'd0;
         held_data_ff      <= 8'd0;
         rx_shift_ff       <= 8'd0;
         ack_ff            <= 3'd0;
         div_ff            <= '0;
         scl_ff            <= 1'b1;
         sda_ff            <= 1'b1;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_DEVICE_ADDRESS: device_address_ff <= csr_write_data[6:0];
               CSR_STEP_TICKS:     step_ticks_ff     <= csr_write_data;
               default:            step_ticks_ff     <= step_ticks_ff;
            endcase
         end
         step_index_ff <= step_index_in;
         is_read_ff    <= is_read_in;
         held_reg_ff   <= held_reg_in;
         held_data_ff  <= held_data_in;
         rx_shift_ff   <= rx_shift_in;
         ack_ff        <= ack_in;
         div_ff        <= div_in;
         scl_ff        <= scl_in;
         sda_ff        <= sda_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload, loaded with the post-tick state
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_scl_ff     <= scl_in;
         rsp_sda_ff     <= sda_in;
         rsp_busy_ff    <= (step_index_in != 7'd0);
         rsp_done_ff    <= done_in;
         rsp_read_ff    <= rx_shift_in;
         rsp_ack_ff     <= ack_in;
         rsp_refused_ff <= refused_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_scl_out         = rsp_scl_ff;
   assign rsp_sda_out         = rsp_sda_ff;
   assign rsp_busy_res        = rsp_busy_ff;
   assign rsp_done_res        = rsp_done_ff;
   assign rsp_read_data       = rsp_read_ff;
   assign rsp_ack_missing     = rsp_ack_ff;
   assign rsp_command_refused = rsp_refused_ff;

   // step index never runs past the longest sequence
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_index_ff <= READ_STEPS)
      else $error("step index out of range");

   // divider is parked at zero while idle
   a_idle_div: assert property (@(posedge clock) disable iff (reset)
      (step_index_ff == 7'd0) |-> (div_ff == '0))
      else $error("divider running while idle");

   // a write never reaches read-only step numbers
   a_write_len: assert property (@(posedge clock) disable iff (reset)
      !is_read_ff |-> (step_index_ff <= WRITE_STEPS))
      else $error("write sequence overran");

   // done only reported alongside not busy
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_done_ff) |-> !rsp_busy_ff)
      else $error("done while busy");

   // an accepted request always leaves a response pending
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("response lost");

endmodule

>>> bench/i2c_master_register_access_test.sv
// ----------------------------------------------------------------------------
// i2c_master_register_access_test: self-checking bench for the I2C master
// Sends tick and start requests through the req_ channel and keeps its own
// copy of the pin sequencer. Every response is checked field by field against
// that copy. Configuration changes between phases, sometimes mid-transaction.
// ----------------------------------------------------------------------------
module i2c_master_register_access_test
   import i2cma_pkg::*;
();

   localparam int          RANDOM_ITEMS = 1200;
   localparam int          CYCLE_LIMIT  = 400000;
   localparam logic [1:0]  OP_SPARE     = 2'd3;    // unused selector, acts as a tick

   // one response as the bench expects it
   typedef struct packed {
      logic       scl;
      logic       sda;
      logic       busy;
      logic       done;
      logic [7:0] rdata;
      logic [2:0] ack_missing;
      logic       refused;
   } bus_state_type;

   // one row of the directed table; typed marks a hand-written expectation in known
   typedef struct packed {
      logic [1:0]    op;
      logic [7:0]    reg_address;
      logic [7:0]    write_data;
      logic          sda_in;
      logic          typed;
      bus_state_type known;
   } stim_row_type;

   // pieces a transaction is built from
   typedef enum logic [3:0] {
      SEG_START, SEG_ADDR_W, SEG_REG, SEG_DATA, SEG_ADDR_R,
      SEG_ACK, SEG_RECV, SEG_NACK, SEG_STOP
   } segment_type;

   typedef enum logic [1:0] {
      STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE
   } stall_type;

   localparam bus_state_type BUS_IDLE = '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 3'd0, 1'b0};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_operation = OP_TICK;
   logic [7:0]  req_reg_address = 8'h00;
   logic [7:0]  req_write_data = 8'h00;
   logic        req_sda_in = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_scl_out;
   logic        rsp_sda_out;
   logic        rsp_busy_res;
   logic        rsp_done_res;
   logic [7:0]  rsp_read_data;
   logic [2:0]  rsp_ack_missing;
   logic        rsp_command_refused;
   logic        csr_write_enable = 1'b0;
   logic        csr_index = CSR_DEVICE_ADDRESS;
   logic [15:0] csr_write_data = 16'h0000;

   i2c_master_register_access dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_reg_address     (req_reg_address),
      .req_write_data      (req_write_data),
      .req_sda_in          (req_sda_in),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_scl_out         (rsp_scl_out),
      .rsp_sda_out         (rsp_sda_out),
      .rsp_busy_res        (rsp_busy_res),
      .rsp_done_res        (rsp_done_res),
      .rsp_read_data       (rsp_read_data),
      .rsp_ack_missing     (rsp_ack_missing),
      .rsp_command_refused (rsp_command_refused),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------------
   // Bench copy of the sequencer: configuration, step position, latches,
   // receive byte, ACK flags, divider and pin levels.
   // ---------------------------------------------------------------------
   logic [6:0]  dev_addr_m   = 7'd97;
   logic [15:0] hold_ticks_m = 16'd1;
   logic [6:0]  step_pos     = 7'd0;    // 0 idle, else 1-based step number
   logic        rd_mode      = 1'b0;
   logic [7:0]  reg_latch    = 8'h00;
   logic [7:0]  data_latch   = 8'h00;
   logic [7:0]  rx_byte      = 8'h00;
   logic [2:0]  ack_miss     = 3'd0;
   int unsigned div_count    = 0;
   logic        scl_level    = 1'b1;
   logic        sda_level    = 1'b1;

   segment_type write_plan [8] = '{SEG_START, SEG_ADDR_W, SEG_ACK, SEG_REG, SEG_ACK,
                                   SEG_DATA, SEG_ACK, SEG_STOP};
   segment_type read_plan [11] = '{SEG_START, SEG_ADDR_W, SEG_ACK, SEG_REG, SEG_ACK,
                                   SEG_START, SEG_ADDR_R, SEG_ACK, SEG_RECV, SEG_NACK,
                                   SEG_STOP};

   bus_state_type pending_bus_states [$];

   int mismatch_count    = 0;
   int responses_checked = 0;
   int requests_sent     = 0;
   int writes_started    = 0;
   int reads_started     = 0;
   int starts_refused    = 0;
   int stops_completed   = 0;
   int settings_applied  = 0;
   int burst_left        = 0;
   int cycle_count       = 0;

   function automatic int unsigned segment_length(segment_type code);
      case (code)
         SEG_START, SEG_ACK: return 4;
         SEG_RECV:           return 25;
         SEG_NACK, SEG_STOP: return 3;
         default:            return 24;
      endcase
   endfunction

   // Carry out the pin action of 0-based step pos.
   function automatic void drive_pin_step(int unsigned pos, logic sda_s);
      int unsigned base, slot, offset, len, nseg;
      segment_type code;
      logic [7:0]  byte_val;
      base = 0;
      slot = 0;
      nseg = rd_mode ? 11 : 8;
      for (int unsigned s = 0; s < nseg; s++) begin
         code = rd_mode ? read_plan[s] : write_plan[s];
         len  = segment_length(code);
         if (pos < base + len) begin
            offset = pos - base;
            case (code)
               SEG_START: begin
                  case (offset)
                     0:       sda_level = 1'b1;
                     1:       scl_level = 1'b1;
                     2:       sda_level = 1'b0;
                     default: scl_level = 1'b0;
                  endcase
               end
               SEG_ACK: begin
                  case (offset)
                     0:       sda_level = 1'b1;
                     1:       scl_level = 1'b1;
                     2:       if (sda_s) ack_miss[slot[1:0]] = 1'b1;
                     default: scl_level = 1'b0;
                  endcase
               end
               SEG_RECV: begin
                  if (offset == 0) begin
                     sda_level = 1'b1;
                  end else begin
                     case ((offset - 1) % 3)
                        0:       scl_level = 1'b1;
                        1:       rx_byte = {rx_byte[6:0], sda_s};
                        default: scl_level = 1'b0;
                     endcase
                  end
               end
               SEG_NACK: begin
                  case (offset)
                     0:       sda_level = 1'b1;
                     1:       scl_level = 1'b1;
                     default: scl_level = 1'b0;
                  endcase
               end
               SEG_STOP: begin
                  case (offset)
                     0:       sda_level = 1'b0;
                     1:       scl_level = 1'b1;
                     default: sda_level = 1'b1;
                  endcase
               end
               default: begin
                  case (code)
                     SEG_ADDR_W: byte_val = {dev_addr_m, 1'b0};
                     SEG_ADDR_R: byte_val = {dev_addr_m, 1'b1};
                     SEG_REG:    byte_val = reg_latch;
                     default:    byte_val = data_latch;
                  endcase
                  // three steps per bit: data, SCL high, SCL low
                  case (offset % 3)
                     0:       sda_level = byte_val[7 - offset / 3];
                     1:       scl_level = 1'b1;
                     default: scl_level = 1'b0;
                  endcase
               end
            endcase
            return;
         end
         if (code == SEG_ACK) slot++;
         base += len;
      end
   endfunction

   // Advance the bench copy by one accepted request and return the response.
   function automatic bus_state_type predict_bus_state(logic [1:0] op, logic [7:0] ra,
                                                       logic [7:0] wd, logic sda_s);
      bus_state_type r;
      int unsigned   hold, cnt, total;
      r.done    = 1'b0;
      r.refused = 1'b0;
      if (step_pos == 0) begin
         // idle: only a start does anything
         if (op == OP_WRITE || op == OP_READ) begin
            rd_mode   = (op == OP_READ);
            reg_latch = ra;
            if (op == OP_WRITE) data_latch = wd;
            else rx_byte = 8'h00;
            ack_miss  = 3'd0;
            div_count = 0;
            step_pos  = 7'd1;
            drive_pin_step(0, sda_s);
            if (op == OP_WRITE) writes_started++;
            else reads_started++;
         end
      end else begin
         hold = (hold_ticks_m == 0) ? 1 : hold_ticks_m;
         cnt  = div_count + 1;
         if (op == OP_WRITE || op == OP_READ) begin
            r.refused = 1'b1;
            starts_refused++;
         end
         if (cnt >= hold || cnt >= (1 << DIVIDER_WIDTH)) begin
            total     = rd_mode ? READ_STEPS : WRITE_STEPS;
            div_count = 0;
            if (step_pos >= total) begin
               step_pos = 7'd0;
               r.done   = 1'b1;
               stops_completed++;
            end else begin
               drive_pin_step(step_pos, sda_s);
               step_pos = step_pos + 7'd1;
            end
         end else begin
            div_count = cnt;
         end
      end
      r.scl         = scl_level;
      r.sda         = sda_level;
      r.busy        = (step_pos != 0);
      r.rdata       = rx_byte;
      r.ack_missing = ack_miss;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Directed table. Rows with typed set carry an expectation read straight
   // off the sequencer: idle after reset, spare selector while idle, a fresh
   // write start, refused starts and a spare selector while busy. The rest
   // walk into the address byte and are checked against the bench copy.
   // ---------------------------------------------------------------------
   stim_row_type directed_rows [20] = '{
      '{OP_TICK,  8'h00, 8'h00, 1'b0, 1'b1, BUS_IDLE},
      '{OP_SPARE, 8'hFF, 8'hFF, 1'b1, 1'b1, BUS_IDLE},
      '{OP_WRITE, 8'hFF, 8'h00, 1'b0, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 3'd0, 1'b0}},
      '{OP_READ,  8'h00, 8'hFF, 1'b1, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 3'd0, 1'b1}},
      '{OP_WRITE, 8'h5A, 8'hA5, 1'b0, 1'b1, '{1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 3'd0, 1'b1}},
      '{OP_SPARE, 8'h00, 8'h00, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 3'd0, 1'b0}},
      '{OP_TICK,  8'hFF, 8'hFF, 1'b1, 1'b0, '0},
      '{OP_TICK,  8'h00, 8'h00, 1'b0, 1'b0, '0},
      '{OP_TICK,  8'hFF, 8'h00, 1'b1, 1'b0, '0},
      '{OP_TICK,  8'h00, 8'hFF, 1'b0, 1'b0, '0},
      '{OP_TICK,  8'h12, 8'h34, 1'b1, 1'b0, '0},
      '{OP_TICK,  8'h80, 8'h01, 1'b0, 1'b0, '0},
      '{OP_TICK,  8'h7F, 8'hFE, 1'b1, 1'b0, '0},
      '{OP_TICK,  8'h00, 8'h00, 1'b0, 1'b0, '0},
      '{OP_TICK,  8'hAA, 8'h55, 1'b1, 1'b0, '0},
      '{OP_TICK,  8'h55, 8'hAA, 1'b0, 1'b0, '0},
      '{OP_TICK,  8'h00, 8'h00, 1'b1, 1'b0, '0},
      '{OP_TICK,  8'hFF, 8'hFF, 1'b0, 1'b0, '0},
      '{OP_TICK,  8'h01, 8'h80, 1'b1, 1'b0, '0},
      '{OP_TICK,  8'h00, 8'h00, 1'b0, 1'b0, '0}
   };

   // Send one request. The sender runs in bursts, and valid drops between
   // bursts. The bench copy advances when the request is taken.
   task automatic send_request(logic [1:0] op, logic [7:0] ra, logic [7:0] wd,
                               logic sda_s, output bus_state_type predicted);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 20);
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_reg_address <= ra;
      req_write_data  <= wd;
      req_sda_in      <= sda_s;
      do @(posedge clock); while (req_stall);
      predicted = predict_bus_state(op, ra, wd, sda_s);
      requests_sent++;
   endtask

   // Hold the sender off until every expected response is back.
   task automatic wait_for_responses();
      req_valid <= 1'b0;
      while (pending_bus_states.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Write both registers back to back; upper address bits are don't-care.
   task automatic configure_bus(logic [6:0] addr, logic [15:0] ticks);
      logic [8:0] upper;
      upper = $urandom_range(0, 511);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_DEVICE_ADDRESS;
      csr_write_data   <= {upper, addr};
      @(posedge clock);
      csr_index        <= CSR_STEP_TICKS;
      csr_write_data   <= ticks;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      dev_addr_m   = addr;
      hold_ticks_m = ticks;
      settings_applied++;
   endtask

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   // ---------------------------------------------------------------------
   // Response checker: oldest expectation against each taken response.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      bus_state_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_bus_states.size() == 0) begin
            $error("response with no request waiting");
            mismatch_count++;
         end else begin
            want = pending_bus_states.pop_front();
            check_field("scl_out", 8'(want.scl), 8'(rsp_scl_out));
            check_field("sda_out", 8'(want.sda), 8'(rsp_sda_out));
            check_field("busy_res", 8'(want.busy), 8'(rsp_busy_res));
            check_field("done_res", 8'(want.done), 8'(rsp_done_res));
            check_field("read_data", want.rdata, rsp_read_data);
            check_field("ack_missing", 8'(want.ack_missing), 8'(rsp_ack_missing));
            check_field("command_refused", 8'(want.refused), 8'(rsp_command_refused));
            responses_checked++;
         end
      end
   end

   // Receiver back-pressure: a mode held for a random stretch, from no
   // stalls at all to mostly stalled.
   stall_type stall_mode      = STALL_NONE;
   int        stall_mode_left = 0;

   always @(posedge clock) begin
      if (stall_mode_left == 0) begin
         stall_mode      <= stall_type'($urandom_range(0, 3));
         stall_mode_left <= $urandom_range(40, 300);
      end else begin
         stall_mode_left <= stall_mode_left - 1;
      end
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 99) < 30);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 99) < 70);
         default:     rsp_stall <= ~rsp_stall;
      endcase
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("i2c_master_register_access_test: FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence: reset, directed table, then random phases. Each phase
   // drains the response queue, applies a new setting and runs a stretch
   // of requests that may end in the middle of a transaction.
   // ---------------------------------------------------------------------
   initial begin
      bus_state_type predicted;
      int          random_sent;
      int          phase_items;
      int          phase_index;
      int          pick;
      logic [1:0]  op;
      logic [6:0]  addr;
      logic [15:0] ticks;
      logic        sda_s;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed part runs on the reset setting
      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].op, directed_rows[i].reg_address,
                      directed_rows[i].write_data, directed_rows[i].sda_in, predicted);
         pending_bus_states.push_back(directed_rows[i].typed ? directed_rows[i].known
                                                             : predicted);
      end

      random_sent = 0;
      phase_index = 0;
      while (random_sent < RANDOM_ITEMS) begin
         wait_for_responses();

         // first phases hit the setting extremes, including zero hold and
         // the longest hold (abandoned after a few dozen ticks)
         phase_items = $urandom_range(80, 260);
         pick = $urandom_range(0, 9);
         addr = (pick == 0) ? 7'd0 : (pick == 1) ? 7'd127 : 7'($urandom_range(0, 127));
         case ($urandom_range(0, 7))
            0:       ticks = 16'd0;
            5:       ticks = 16'd2;
            6:       ticks = 16'd3;
            7:       ticks = 16'($urandom_range(1, 5));
            default: ticks = 16'd1;
         endcase
         if (phase_index == 0) begin
            addr  = 7'd0;
            ticks = 16'd1;
         end else if (phase_index == 1) begin
            addr  = 7'd127;
            ticks = 16'd0;
         end else if (phase_index == 2) begin
            ticks       = 16'hFFFF;
            phase_items = 40;
         end
         // last phase stops at the item budget
         if (phase_items > RANDOM_ITEMS - random_sent) begin
            phase_items = RANDOM_ITEMS - random_sent;
         end
         configure_bus(addr, ticks);

         repeat (phase_items) begin
            // mostly clean transactions; a few refused starts and spare
            // selectors mixed in as noise
            pick = $urandom_range(0, 99);
            if (step_pos == 0) begin
               if (pick < 85) op = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
               else if (pick < 93) op = OP_TICK;
               else op = OP_SPARE;
            end else begin
               if (pick < 94) op = OP_TICK;
               else if (pick < 97) op = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
               else op = OP_SPARE;
            end
            // SDA low most of the time so ACKs mostly arrive
            sda_s = ($urandom_range(0, 99) < 35);
            send_request(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         sda_s, predicted);
            pending_bus_states.push_back(predicted);
            random_sent++;
         end
         phase_index++;
      end

      wait_for_responses();
      repeat (4) @(posedge clock);

      $display("ran %0d requests over %0d settings: %0d writes, %0d reads, %0d stops, %0d refused",
               requests_sent, settings_applied, writes_started, reads_started,
               stops_completed, starts_refused);
      $display("checked %0d responses, %0d mismatches", responses_checked, mismatch_count);
      if (mismatch_count == 0 && pending_bus_states.size() == 0) begin
         $display("i2c_master_register_access_test: PASS");
      end else begin
         $display("i2c_master_register_access_test: FAIL");
      end
      $finish;
   end

endmodule
